>>> hw/rtl/fqr_pkg.sv
// Shared types and codes for the FIFO queue with remove-by-id.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fqr_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_SERVE  = 2'd1;
  localparam logic [1:0] MODE_LEAVE  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int unsigned ID_W  = 32;
  localparam int unsigned OCC_W = 5;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [ID_W-1:0] student_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [ID_W-1:0] served_id;
    logic [OCC_W-1:0]       occupancy;
  } out_item_t;

  // Operation broadcast to every cell in the chain
  typedef struct packed {
    logic            append;
    logic            serve;
    logic            leave;
    logic [ID_W-1:0] id;
  } cell_op_t;

  // Per-cell position flags, derived from the fill count and the cell index
  typedef struct packed {
    logic valid;
    logic at_tail;
    logic is_head;
  } cell_pos_t;

endpackage

>>> hw/rtl/fqr_cell.sv
// One storage cell of the queue chain: holds one id, matches, and shifts.
// Depends on fqr_pkg.
`timescale 1ns / 1ps

module fqr_cell
  import fqr_pkg::*;
(
  input  logic            clk,
  input  cell_op_t        op,
  input  cell_pos_t       pos,
  input  logic            found_in,
  input  logic [ID_W-1:0] acc_in,
  input  logic [ID_W-1:0] next_data,
  output logic            found_out,
  output logic [ID_W-1:0] acc_out,
  output logic [ID_W-1:0] data
);

  logic [ID_W-1:0] data_r;
  logic [ID_W-1:0] data_nxt;
  logic            hit;

  // First hit in the chain: head for serve, oldest equal id for leave
  assign hit = pos.valid && !found_in &&
               ((op.serve && pos.is_head) || (op.leave && (data_r == op.id)));

  assign found_out = found_in || hit;
  assign acc_out   = acc_in | (hit ? data_r : '0);
  assign data      = data_r;

  always_comb begin
    data_nxt = data_r;
    if (found_out && pos.valid) begin
      // close the gap: take the younger neighbor's id
      data_nxt = next_data;
    end else if (op.append && pos.at_tail) begin
      data_nxt = op.id;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> hw/rtl/fifo_queue_with_remove_by_id.sv
// Top level of the FIFO queue with remove-by-id: a chain of fqr_cell
// storage cells plus the fill count and the result register.
// Depends on fqr_pkg and fqr_cell.
`timescale 1ns / 1ps

// Bounded FIFO of 32-bit ids built as a shift-register chain of DEPTH cells,
// head in cell 0. Every transaction (append, serve, leave) runs without a
// stall: busy never rises, so a new transaction may be started on every clock.
// The result of a transaction accepted at edge N appears on out_data with
// out_valid high during the cycle after edge N, for exactly that one cycle;
// the receiver cannot stall and must capture it then. Leave searches all cells
// in parallel, picks the oldest match through the found chain that ripples
// from head to tail, and shifts all younger entries one place toward the head.
// The length of that chain (one compare and one gate per cell) sets the clock
// period. occupancy reports the low five bits of the fill count afterward.
module fifo_queue_with_remove_by_id
  import fqr_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  out_item_t     out_data_r;
  out_item_t     out_data_nxt;

  cell_op_t        op;
  logic            accept;
  logic            full;
  logic            empty;
  logic            found [0:DEPTH];
  logic [ID_W-1:0] acc   [0:DEPTH];
  logic [ID_W-1:0] data  [0:DEPTH-1];

  // One transaction per cycle; nothing ever holds the requester off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Broadcast the operation; drop append when full and removals when empty
  assign op.append = accept && (in_data.mode == MODE_APPEND) && !full;
  assign op.serve  = accept && (in_data.mode == MODE_SERVE) && !empty;
  assign op.leave  = accept && (in_data.mode == MODE_LEAVE) && !empty;
  assign op.id     = in_data.student_id;

  assign found[0] = 1'b0;
  assign acc[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_pos_t       pos;
    logic [ID_W-1:0] next_data;

    assign pos.valid   = (CW'(i) < count_r);
    assign pos.at_tail = (CW'(i) == count_r);
    assign pos.is_head = (i == 0);

    // The last cell has no younger neighbor; its shifted-in value is never read
    if (i == DEPTH - 1) begin : g_last
      assign next_data = op.id;
    end else begin : g_mid
      assign next_data = data[i+1];
    end

    fqr_cell u_cell (
      .clk       (clk),
      .op        (op),
      .pos       (pos),
      .found_in  (found[i]),
      .acc_in    (acc[i]),
      .next_data (next_data),
      .found_out (found[i+1]),
      .acc_out   (acc[i+1]),
      .data      (data[i])
    );
  end

  // Fill count and result contents
  always_comb begin
    count_nxt              = count_r;
    out_data_nxt.status    = ST_OK;
    out_data_nxt.served_id = '0;
    unique case (in_data.mode) inside
      MODE_APPEND: begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_SERVE, MODE_LEAVE: begin
        if (empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else if (found[DEPTH]) begin
          count_nxt              = count_r - CW'(1);
          out_data_nxt.served_id = acc[DEPTH];
        end else begin
          out_data_nxt.status = ST_NOTFOUND;
        end
      end
      default: begin
        // unused code: no change, report ok
        out_data_nxt.status = ST_OK;
      end
    endcase
    out_data_nxt.occupancy = OCC_W'(32'(count_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    // hold the result payload with the transaction that produced it
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
